@@ hw/rtl/sha256_hash_stream_top_macros.svh @@
// Assertion macros for the SHA-256 stream hasher.
// Taken in by sha256_hash_stream_top; expects aclk and aresetn in scope.
`ifndef SHA256_HASH_STREAM_TOP_MACROS_SVH
`define SHA256_HASH_STREAM_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SHA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A same-cycle implication.
`define SHA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// An implication checked in the next cycle.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sha256_pkg.sv @@
// Shared types, constants and functions for the SHA-256 stream hasher.
// No dependencies; used by every module of the block.
`default_nettype none

package sha256_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [7:0]       hash_t;
    typedef word_t [15:0]      block_t;

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic push;   // shift a new message word into the window
        logic shift;  // advance the window by one expanded word
    } sched_ctl_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;   // take the chaining value as working variables
        logic step;   // run one compression round
    } core_ctl_t;

    // Initial hash value, element 0 is H0.
    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants, element 0 first.
    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t PAD_WORD = 32'h8000_0000;

    // Small sigma functions of the message schedule.
    function automatic word_t sig0(input word_t x);
        sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Large sigma functions of the round.
    function automatic word_t ep0(input word_t x);
        ep0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t ep1(input word_t x);
        ep1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Bytes kept in the final word for a saturated count of 0 to 4.
    function automatic word_t keep_mask(input logic [2:0] n);
        case (n)
            3'd0:    keep_mask = 32'h0000_0000;
            3'd1:    keep_mask = 32'hff00_0000;
            3'd2:    keep_mask = 32'hffff_0000;
            3'd3:    keep_mask = 32'hffff_ff00;
            default: keep_mask = 32'hffff_ffff;
        endcase
    endfunction

    // Padding byte placed just after the kept bytes; a full word has none.
    function automatic word_t pad_mark(input logic [2:0] n);
        case (n)
            3'd0:    pad_mark = 32'h8000_0000;
            3'd1:    pad_mark = 32'h0080_0000;
            3'd2:    pad_mark = 32'h0000_8000;
            3'd3:    pad_mark = 32'h0000_0080;
            default: pad_mark = 32'h0000_0000;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha256_sched.sv @@
// Message block window and schedule expansion of the SHA-256 hasher.
// Depends on sha256_pkg.
`default_nettype none

module sha256_sched (
    input  wire logic                    aclk,
    input  wire sha256_pkg::sched_ctl_t  ctl,
    input  wire sha256_pkg::word_t       push_word,
    output sha256_pkg::word_t            w_out
);
    import sha256_pkg::*;

    block_t w_reg;
    block_t w_next;
    word_t  w_new;

    // Next expanded word from the sixteen-word window.
    assign w_new = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);

    // Both loading and expansion shift the window towards element 0.
    always_comb begin
        w_next = w_reg;
        if (ctl.push) begin
            w_next = {push_word, w_reg[15:1]};
        end else if (ctl.shift) begin
            w_next = {w_new, w_reg[15:1]};
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

    assign w_out = w_reg[0];

endmodule

`default_nettype wire

@@ hw/rtl/sha256_round.sv @@
// Shared compression round unit of the SHA-256 hasher: eight working
// variables and one round per step. Depends on sha256_pkg.
`default_nettype none

module sha256_round (
    input  wire logic                   aclk,
    input  wire sha256_pkg::core_ctl_t  ctl,
    input  wire sha256_pkg::hash_t      chain_in,
    input  wire sha256_pkg::word_t      k_in,
    input  wire sha256_pkg::word_t      w_in,
    output sha256_pkg::hash_t           v_out
);
    import sha256_pkg::*;

    hash_t v_reg;
    hash_t v_next;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    // Round function; element 0 is a, element 7 is h.
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + ep1(v_reg[4]) + ch + k_in + w_in;
    assign t2  = ep0(v_reg[0]) + maj;

    always_comb begin
        v_next = v_reg;
        if (ctl.load) begin
            v_next = chain_in;
        end else if (ctl.step) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

    assign v_out = v_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sha256_hash_stream_top.sv @@
// SHA-256 stream hasher: top level with the block sequencer, padding and
// digest output. Depends on sha256_pkg, sha256_sched, sha256_round and the macros header.
//
// Message words are taken one per beat while the block is idle. A word that
// does not complete a 16-word block leaves s_ready high; a word that completes
// one is pushed, then runs 64 rounds through the single shared round unit
// and a fold of the result into the chaining value, during which s_ready is
// low. On the final word the padding words are pushed one per cycle, with the
// 64 rounds and the fold after each block they complete, and the eight digest
// words then leave on m_ one beat each, index 0 first, with m_digest_last on
// the eighth. The block takes no input until the last digest beat has gone,
// after which it starts again from the initial hash.
`default_nettype none
`include "sha256_hash_stream_top_macros.svh"

module sha256_hash_stream_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sha256_pkg::word_t  s_msg_word,
    input  wire logic [2:0]         s_byte_count,
    input  wire logic               s_final_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sha256_pkg::word_t       m_digest_word,
    output logic [2:0]              m_word_index,
    output logic                    m_digest_last
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    hash_t       chain_reg, chain_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad80_reg, pad80_next;
    logic        pad_active_reg, pad_active_next;
    logic        len_hi_reg, len_hi_next;
    logic        out_pend_reg, out_pend_next;

    sched_ctl_t  sched_ctl;
    core_ctl_t   core_ctl;
    word_t       push_word;
    logic        push_en;
    logic [2:0]  n_sat;
    word_t       w_cur;
    hash_t       v_cur;

    // Oversized byte counts on the final word saturate to a full word.
    assign n_sat = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_digest_last = (out_idx_reg == 3'd7);

    // Sequencer: word loading, padding, rounds, chaining and digest beats.
    always_comb begin
        state_next      = state_reg;
        chain_next      = chain_reg;
        pos_next        = pos_reg;
        bits_next       = bits_reg;
        rnd_next        = rnd_reg;
        out_idx_next    = out_idx_reg;
        pad80_next      = pad80_reg;
        pad_active_next = pad_active_reg;
        len_hi_next     = len_hi_reg;
        out_pend_next   = out_pend_reg;
        push_en         = 1'b0;
        push_word       = '0;
        sched_ctl       = '0;
        core_ctl        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    push_en = 1'b1;
                    if (s_final_word) begin
                        bits_next       = bits_reg + {58'b0, n_sat, 3'b000};
                        push_word       = (s_msg_word & keep_mask(n_sat)) | pad_mark(n_sat);
                        pad80_next      = (n_sat == 3'd4);
                        pad_active_next = 1'b1;
                        len_hi_next     = 1'b0;
                        state_next      = ST_PAD;
                    end else begin
                        bits_next = bits_reg + 64'd32;
                        push_word = s_msg_word;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (pad80_reg) begin
                    push_word  = PAD_WORD;
                    pad80_next = 1'b0;
                end else if (pos_reg == 4'd14) begin
                    push_word   = bits_reg[63:32];
                    len_hi_next = 1'b1;
                end else if (pos_reg == 4'd15 && len_hi_reg) begin
                    push_word       = bits_reg[31:0];
                    pad_active_next = 1'b0;
                    out_pend_next   = 1'b1;
                end else begin
                    push_word = '0;
                end
            end
            ST_COMP: begin
                core_ctl.step   = 1'b1;
                sched_ctl.shift = 1'b1;
                rnd_next        = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_cur[i];
                end
                if (out_pend_reg) begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end else if (pad_active_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        chain_next    = INIT_HASH;
                        bits_next     = '0;
                        out_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A word entering the window; the sixteenth starts the rounds.
        if (push_en) begin
            sched_ctl.push = 1'b1;
            pos_next       = pos_reg + 4'd1;
            if (pos_reg == 4'd15) begin
                core_ctl.load = 1'b1;
                rnd_next      = '0;
                state_next    = ST_COMP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            chain_reg      <= INIT_HASH;
            pos_reg        <= '0;
            bits_reg       <= '0;
            rnd_reg        <= '0;
            out_idx_reg    <= '0;
            pad80_reg      <= 1'b0;
            pad_active_reg <= 1'b0;
            len_hi_reg     <= 1'b0;
            out_pend_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            pos_reg        <= pos_next;
            bits_reg       <= bits_next;
            rnd_reg        <= rnd_next;
            out_idx_reg    <= out_idx_next;
            pad80_reg      <= pad80_next;
            pad_active_reg <= pad_active_next;
            len_hi_reg     <= len_hi_next;
            out_pend_reg   <= out_pend_next;
        end
    end

    // Message window and expansion.
    sha256_sched u_sched (
        .aclk      (aclk),
        .ctl       (sched_ctl),
        .push_word (push_word),
        .w_out     (w_cur)
    );

    // Shared round unit.
    sha256_round u_round (
        .aclk     (aclk),
        .ctl      (core_ctl),
        .chain_in (chain_reg),
        .k_in     (ROUND_K[rnd_reg]),
        .w_in     (w_cur),
        .v_out    (v_cur)
    );

    // Checks on the sequencer.
    `SHA_ASSERT_ALWAYS(a_in_out_excl, !(s_ready && m_valid), "input and output open together")
    `SHA_ASSERT_IMPLY(a_rnd_idle, state_reg != ST_COMP, rnd_reg == 6'd0, "stray round count")
    `SHA_ASSERT_IMPLY(a_comp_pos, state_reg == ST_COMP, pos_reg == 4'd0, "partial block in rounds")
    `SHA_ASSERT_NEXT(a_ready_after, m_valid && m_ready && m_digest_last, s_ready, "no restart")

endmodule

`default_nettype wire
